// ----- sv/rhsi_pkg.sv -----
// shared constants, types and the arctangent table for the rgb to hsi converter
// no dependencies
package rhsi_pkg;

    localparam int CORDIC_STEPS = 20;
    localparam int DIV_STEPS    = 13;
    localparam int XW           = 29;   // cordic x / y width, signed
    localparam int ZW           = 26;   // angle accumulator width, signed, degrees q16
    localparam int NW           = 23;   // saturation dividend width
    localparam int DW           = 11;   // saturation divisor width

    localparam logic [16:0] SQRT3_Q16   = 17'd113512;
    localparam logic [15:0] RECIP3_Q17  = 16'd43691;
    localparam logic signed [ZW-1:0] DEG90_Q16  = ZW'(5898240);
    localparam logic signed [ZW-1:0] DEG180_Q16 = ZW'(11796480);
    localparam logic [14:0] HUE_FULL    = 15'd23040;

    typedef struct packed {
        logic        gray;
        logic        b_gt_g;
        logic        black;
        logic [13:0] inten;
    } t_side;

    // atan(2^-i) in degrees, q16
    function automatic logic signed [ZW-1:0] atan_q16(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:       v = ZW'(2949120);
            1:       v = ZW'(1740967);
            2:       v = ZW'(919879);
            3:       v = ZW'(466945);
            4:       v = ZW'(234379);
            5:       v = ZW'(117304);
            6:       v = ZW'(58666);
            7:       v = ZW'(29335);
            8:       v = ZW'(14668);
            9:       v = ZW'(7334);
            10:      v = ZW'(3667);
            11:      v = ZW'(1833);
            12:      v = ZW'(917);
            13:      v = ZW'(458);
            14:      v = ZW'(229);
            15:      v = ZW'(115);
            16:      v = ZW'(57);
            17:      v = ZW'(29);
            18:      v = ZW'(14);
            19:      v = ZW'(7);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- sv/rhsi_cordic.sv -----
// pipelined vectoring cordic, one micro-rotation per register stage
// depends on rhsi_pkg
module rhsi_cordic import rhsi_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    output logic                 o_valid,
    output logic signed [ZW-1:0] o_z
);

    logic                 r_vld [CORDIC_STEPS];
    logic signed [XW-1:0] r_x   [CORDIC_STEPS];
    logic signed [XW-1:0] r_y   [CORDIC_STEPS];
    logic signed [ZW-1:0] r_z   [CORDIC_STEPS];

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        logic signed [XW-1:0] x_in, y_in, n_x, n_y;
        logic signed [ZW-1:0] z_in, n_z;
        logic                 v_in;

        if (k == 0) begin : g_first
            assign x_in = i_x;
            assign y_in = i_y;
            assign z_in = i_z;
            assign v_in = i_valid;
        end else begin : g_rest
            assign x_in = r_x[k-1];
            assign y_in = r_y[k-1];
            assign z_in = r_z[k-1];
            assign v_in = r_vld[k-1];
        end

        always_comb begin
            if (y_in > 0) begin
                n_x = x_in + (y_in >>> k);
                n_y = y_in - (x_in >>> k);
                n_z = z_in + atan_q16(k);
            end else begin
                n_x = x_in - (y_in >>> k);
                n_y = y_in + (x_in >>> k);
                n_z = z_in - atan_q16(k);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= v_in;
            end
            r_x[k] <= n_x;
            r_y[k] <= n_y;
            r_z[k] <= n_z;
        end
    end

    assign o_valid = r_vld[CORDIC_STEPS-1];
    assign o_z     = r_z[CORDIC_STEPS-1];

endmodule

// ----- sv/rhsi_div.sv -----
// pipelined restoring divider for saturation, one quotient bit per stage
// depends on rhsi_pkg
module rhsi_div import rhsi_pkg::*; (
    input  logic                 i_clk,
    input  logic [NW-1:0]        i_num,
    input  logic [DW-1:0]        i_den,
    output logic [DIV_STEPS-1:0] o_quot
);

    logic [NW-1:0]        r_rem  [DIV_STEPS];
    logic [DW-1:0]        r_den  [DIV_STEPS];
    logic [DIV_STEPS-1:0] r_quot [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
        localparam int SH = DIV_STEPS - 1 - j;
        logic [NW-1:0]        rem_in;
        logic [DW-1:0]        den_in;
        logic [DIV_STEPS-1:0] q_in;
        logic [NW:0]          sub;

        if (j == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign q_in   = '0;
        end else begin : g_rest
            assign rem_in = r_rem[j-1];
            assign den_in = r_den[j-1];
            assign q_in   = r_quot[j-1];
        end

        assign sub = (NW+1)'(den_in) << SH;

        always_ff @(posedge i_clk) begin
            r_den[j] <= den_in;
            if ({1'b0, rem_in} >= sub) begin
                r_rem[j]  <= NW'({1'b0, rem_in} - sub);
                r_quot[j] <= q_in | (DIV_STEPS'(1) << SH);
            end else begin
                r_rem[j]  <= rem_in;
                r_quot[j] <= q_in;
            end
        end
    end

    assign o_quot = r_quot[DIV_STEPS-1];

endmodule

// ----- sv/rgb_to_hsi_pixel_converter_unit.sv -----
// top level of the rgb to hsi pixel converter
// depends on rhsi_pkg, rhsi_cordic and rhsi_div
//
// Converts one 8-bit rgb pixel per clock into hue (degrees, q6), saturation
// (q12) and intensity (q6). A transaction is taken on every clock edge where
// start is high and busy is low; busy is high only while reset is asserted,
// since the pipeline never stalls, and the receiver cannot hold results off.
// Each result is on the output ports for one cycle with o_valid high. The
// path from pixel to result has 23 register stages: one input register,
// one setup stage, twenty cordic stages for the hue angle and one output
// stage. Results leave in the order the pixels came in. The saturation
// divider runs thirteen stages alongside the cordic. No reset pass is
// needed; reset only clears the valid bits.
module rgb_to_hsi_pixel_converter_unit import rhsi_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    output logic        o_valid,
    output logic [14:0] o_hue_deg,
    output logic [12:0] o_saturation,
    output logic [13:0] o_intensity
);

    localparam int SAT_DLY = CORDIC_STEPS - DIV_STEPS;

    // never stalls, refuses transactions only during reset
    assign busy = ~i_rst_n;

    // stage 1: input register
    logic       r_s1_vld;
    logic [7:0] r_s1_r, r_s1_g, r_s1_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= start & ~busy;
        end
        r_s1_r <= i_red_in;
        r_s1_g <= i_green_in;
        r_s1_b <= i_blue_in;
    end

    // stage 2 setup: sums, min, cordic start vector, divider operands
    logic [9:0]           sum;
    logic [7:0]           mn;
    logic [7:0]           abs_gb;
    logic signed [10:0]   diff_x;
    logic signed [XW-1:0] x0;
    logic [24:0]          y_mag;
    logic [15:0]          inten_num;
    logic [31:0]          inten_prod;
    logic [9:0]           chroma;
    logic signed [XW-1:0] n_x;
    logic signed [XW-1:0] n_y;
    logic signed [ZW-1:0] n_z;
    t_side                n_side;

    always_comb begin
        sum = 10'(r_s1_r) + 10'(r_s1_g) + 10'(r_s1_b);
        mn  = r_s1_r;
        if (r_s1_g < mn) begin
            mn = r_s1_g;
        end
        if (r_s1_b < mn) begin
            mn = r_s1_b;
        end
        abs_gb = (r_s1_g >= r_s1_b) ? (r_s1_g - r_s1_b) : (r_s1_b - r_s1_g);
        diff_x = $signed({2'b00, r_s1_r, 1'b0}) - $signed({3'b000, r_s1_g})
               - $signed({3'b000, r_s1_b});
        x0     = XW'(diff_x) <<< 16;
        y_mag  = 25'(abs_gb * SQRT3_Q16);

        // negative x: rotate by -90 degrees first
        if (x0 < 0) begin
            n_x = $signed(XW'(y_mag));
            n_y = -x0;
            n_z = DEG90_Q16;
        end else begin
            n_x = x0;
            n_y = $signed(XW'(y_mag));
            n_z = '0;
        end

        // round(64*sum/3) via reciprocal multiply
        inten_num  = {sum, 6'b0} + 16'd1;
        inten_prod = inten_num * RECIP3_Q17;
        chroma     = sum - 10'(3 * mn);

        n_side.gray   = (r_s1_r == r_s1_g) && (r_s1_g == r_s1_b);
        n_side.b_gt_g = r_s1_b > r_s1_g;
        n_side.black  = sum == 10'd0;
        n_side.inten  = inten_prod[30:17];
    end

    logic                 r_s2_vld;
    logic signed [XW-1:0] r_s2_x, r_s2_y;
    logic signed [ZW-1:0] r_s2_z;
    logic [NW-1:0]        r_s2_num;
    logic [DW-1:0]        r_s2_den;
    t_side                r_s2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        r_s2_x    <= n_x;
        r_s2_y    <= n_y;
        r_s2_z    <= n_z;
        r_s2_num  <= {chroma, 13'b0} + NW'(sum);
        r_s2_den  <= {sum, 1'b0};
        r_s2_side <= n_side;
    end

    // hue angle
    logic                 cor_vld;
    logic signed [ZW-1:0] cor_z;

    rhsi_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s2_vld),
        .i_x     (r_s2_x),
        .i_y     (r_s2_y),
        .i_z     (r_s2_z),
        .o_valid (cor_vld),
        .o_z     (cor_z)
    );

    // saturation quotient, then delayed to line up with the cordic
    logic [DIV_STEPS-1:0] div_q;

    rhsi_div u_div (
        .i_clk  (i_clk),
        .i_num  (r_s2_num),
        .i_den  (r_s2_den),
        .o_quot (div_q)
    );

    logic [DIV_STEPS-1:0] r_sat_dly [SAT_DLY];
    t_side                r_side_dly [CORDIC_STEPS];

    always_ff @(posedge i_clk) begin
        r_sat_dly[0]  <= div_q;
        r_side_dly[0] <= r_s2_side;
        for (int i = 1; i < SAT_DLY; i++) begin
            r_sat_dly[i] <= r_sat_dly[i-1];
        end
        for (int i = 1; i < CORDIC_STEPS; i++) begin
            r_side_dly[i] <= r_side_dly[i-1];
        end
    end

    // output stage: clamp, round to q6, mirror for blue above green, zero gray hue / black sat
    t_side                fin_side;
    logic signed [ZW-1:0] z_clamp;
    logic [ZW-1:0]        z_round;
    logic [14:0]          hue_half;
    logic [14:0]          n_hue;
    logic [12:0]          n_sat;

    always_comb begin
        fin_side = r_side_dly[CORDIC_STEPS-1];
        if (cor_z < 0) begin
            z_clamp = '0;
        end else if (cor_z > DEG180_Q16) begin
            z_clamp = DEG180_Q16;
        end else begin
            z_clamp = cor_z;
        end
        z_round  = $unsigned(z_clamp) + ZW'(512);
        hue_half = 15'(z_round >> 10);
        if (fin_side.gray) begin
            n_hue = '0;
        end else if (fin_side.b_gt_g) begin
            n_hue = HUE_FULL - hue_half;
        end else begin
            n_hue = hue_half;
        end
        n_sat = fin_side.black ? 13'd0 : r_sat_dly[SAT_DLY-1];
    end

    logic        r_out_vld;
    logic [14:0] r_hue;
    logic [12:0] r_sat;
    logic [13:0] r_inten;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= cor_vld;
        end
        r_hue   <= n_hue;
        r_sat   <= n_sat;
        r_inten <= fin_side.inten;
    end

    assign o_valid      = r_out_vld;
    assign o_hue_deg    = r_hue;
    assign o_saturation = r_sat;
    assign o_intensity  = r_inten;

endmodule

// ----- verif/rgb_to_hsi_pixel_converter_unit_tb.sv -----
// self-checking testbench for the rgb to hsi pixel converter
// depends on rhsi_pkg and rgb_to_hsi_pixel_converter_unit
`timescale 1ns / 100ps

module rgb_to_hsi_pixel_converter_unit_tb import rhsi_pkg::*;;

    localparam int LATENCY     = 23;
    localparam int RANDOM_PIX  = 1100;
    localparam int CYCLE_LIMIT = 200000;

    // one converted pixel
    typedef struct packed {
        logic [14:0] hue;
        logic [12:0] sat;
        logic [13:0] inten;
    } t_hsi;

    // one directed row; check_const set when the expected value is typed in
    typedef struct {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        bit         check_const;
        t_hsi       hsi;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [7:0]  i_red_in;
    logic [7:0]  i_green_in;
    logic [7:0]  i_blue_in;
    logic        o_valid;
    logic [14:0] o_hue_deg;
    logic [12:0] o_saturation;
    logic [13:0] o_intensity;

    t_hsi hsi_expected_q[$];
    int   n_errors;
    int   cycle_cnt;

    rgb_to_hsi_pixel_converter_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .o_valid      (o_valid),
        .o_hue_deg    (o_hue_deg),
        .o_saturation (o_saturation),
        .o_intensity  (o_intensity)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // floor division by a power of two, also for negative values
    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    // arctangent of 2^-i in degrees q16
    function automatic longint atan_step_q16(int i);
        longint tbl[CORDIC_STEPS] = '{
            2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
            14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};
        return tbl[i];
    endfunction

    // vectoring cordic, angle of (x, y) with y >= 0, q6 degrees
    function automatic int vector_angle_q6(longint x, longint y);
        longint ang;
        longint xs;
        longint ys;
        longint t;
        ang = 0;
        // left half plane: pre-rotate by -90 degrees
        if (x < 0) begin
            t   = x;
            x   = y;
            y   = -t;
            ang = 5898240;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = floor_shr(x, i);
            ys = floor_shr(y, i);
            if (y > 0) begin
                x   = x + ys;
                y   = y - xs;
                ang = ang + atan_step_q16(i);
            end else begin
                x   = x - ys;
                y   = y + xs;
                ang = ang - atan_step_q16(i);
            end
        end
        if (ang < 0) ang = 0;
        if (ang > 11796480) ang = 11796480;
        return int'((ang + 512) >>> 10);
    endfunction

    // predicted hue, saturation and intensity of one pixel
    function automatic t_hsi convert_pixel(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8);
        longint r;
        longint g;
        longint b;
        longint sum;
        longint mn;
        longint dgb;
        int     h;
        t_hsi   res;
        r   = r8;
        g   = g8;
        b   = b8;
        sum = r + g + b;
        mn  = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        res.inten = 14'((64 * sum + 1) / 3);
        // black has zero saturation
        res.sat = (sum != 0) ? 13'((8192 * (sum - 3 * mn) + sum) / (2 * sum)) : 13'd0;
        if (r == g && g == b) begin
            h = 0;
        end else begin
            dgb = g - b;
            h = vector_angle_q6((2 * r - g - b) * 65536,
                                (dgb < 0 ? -dgb : dgb) * longint'(SQRT3_Q16));
            // mirror when blue beats green
            if (b > g) h = int'(HUE_FULL) - h;
        end
        res.hue = 15'(h);
        return res;
    endfunction

    // append one expected result to the scoreboard
    function automatic void queue_expected(t_hsi v);
        hsi_expected_q.insert(hsi_expected_q.size(), v);
    endfunction

    // drive one transaction; start stays high into the next one when no gap
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, t_hsi hsi_exp);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_red_in   <= r;
        i_green_in <= g;
        i_blue_in  <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        queue_expected(hsi_exp);
    endtask

    // result checker, receiver cannot stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (hsi_expected_q.size() == 0) begin
                $display("%0t: unexpected result hue %0d sat %0d inten %0d",
                         $time, o_hue_deg, o_saturation, o_intensity);
                n_errors++;
            end else begin
                t_hsi e;
                e = hsi_expected_q.pop_front();
                if (o_hue_deg !== e.hue) begin
                    $display("%0t: hue expected %0d actual %0d", $time, e.hue, o_hue_deg);
                    n_errors++;
                end
                if (o_saturation !== e.sat) begin
                    $display("%0t: saturation expected %0d actual %0d",
                             $time, e.sat, o_saturation);
                    n_errors++;
                end
                if (o_intensity !== e.inten) begin
                    $display("%0t: intensity expected %0d actual %0d",
                             $time, e.inten, o_intensity);
                    n_errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        t_row rows[20];
        t_hsi e;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        int   kind;
        n_errors   = 0;
        cycle_cnt  = 0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_red_in   = '0;
        i_green_in = '0;
        i_blue_in  = '0;

        // black, white and pure red typed in; the rest from the predictor
        rows[0]  = '{8'd0,   8'd0,   8'd0,   1, '{15'd0, 13'd0, 14'd0}};
        rows[1]  = '{8'd255, 8'd255, 8'd255, 1, '{15'd0, 13'd0, 14'd16320}};
        rows[2]  = '{8'd255, 8'd0,   8'd0,   1, '{15'd0, 13'd4096, 14'd5440}};
        rows[3]  = '{8'd0,   8'd255, 8'd0,   0, '{0, 0, 0}};
        rows[4]  = '{8'd0,   8'd0,   8'd255, 0, '{0, 0, 0}};
        rows[5]  = '{8'd128, 8'd128, 8'd128, 0, '{0, 0, 0}};
        rows[6]  = '{8'd255, 8'd255, 8'd0,   0, '{0, 0, 0}};
        rows[7]  = '{8'd0,   8'd255, 8'd255, 0, '{0, 0, 0}};
        rows[8]  = '{8'd255, 8'd0,   8'd255, 0, '{0, 0, 0}};
        rows[9]  = '{8'd0,   8'd1,   8'd0,   0, '{0, 0, 0}};
        rows[10] = '{8'd0,   8'd0,   8'd1,   0, '{0, 0, 0}};
        rows[11] = '{8'd255, 8'd254, 8'd255, 0, '{0, 0, 0}};
        rows[12] = '{8'd255, 8'd255, 8'd254, 0, '{0, 0, 0}};
        rows[13] = '{8'd255, 8'd0,   8'd1,   0, '{0, 0, 0}};
        rows[14] = '{8'd255, 8'd1,   8'd0,   0, '{0, 0, 0}};
        rows[15] = '{8'd0,   8'd200, 8'd201, 0, '{0, 0, 0}};
        rows[16] = '{8'd0,   8'd201, 8'd200, 0, '{0, 0, 0}};
        rows[17] = '{8'd1,   8'd0,   8'd0,   0, '{0, 0, 0}};
        rows[18] = '{8'd170, 8'd85,  8'd85,  0, '{0, 0, 0}};
        rows[19] = '{8'd10,  8'd200, 8'd100, 0, '{0, 0, 0}};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            e = rows[k].check_const ? rows[k].hsi
                                    : convert_pixel(rows[k].r, rows[k].g, rows[k].b);
            send_pixel(rows[k].r, rows[k].g, rows[k].b, e);
        end

        // random pixels, with gray, near-gray and equal-pair cases mixed in
        for (int n = 0; n < RANDOM_PIX; n++) begin
            r    = 8'($urandom_range(0, 255));
            g    = 8'($urandom_range(0, 255));
            b    = 8'($urandom_range(0, 255));
            kind = $urandom_range(0, 9);
            case (kind)
                0: begin
                    g = r;
                    b = r;
                end
                1: begin
                    g = r;
                end
                2: begin
                    b = g;
                end
                3: begin
                    g = r + 8'($urandom_range(0, 2));
                    b = r - 8'($urandom_range(0, 2));
                end
                default: ;
            endcase
            send_pixel(r, g, b, convert_pixel(r, g, b));
        end
        start <= 1'b0;

        while (hsi_expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- rgb_to_hsi_pixel_converter_unit.f -----
sv/rhsi_pkg.sv
sv/rhsi_cordic.sv
sv/rhsi_div.sv
sv/rgb_to_hsi_pixel_converter_unit.sv
verif/rgb_to_hsi_pixel_converter_unit_tb.sv
